// ===== hdl/bfha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfha_pkg: shared constants of the best-fit heap allocator
// Field widths of the request and response channels and the operation
// and status codes.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int REQ_W  = 13;
  localparam int OFF_W  = 12;
  localparam int WORD_W = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

endpackage

// ===== hdl/bfha_if.sv =====
// ----------------------------------------------------------------------------
// bfha request and response channels
// Valid/ready channels that carry allocator requests and their responses.
// ----------------------------------------------------------------------------
interface bfha_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [bfha_pkg::REQ_W-1:0]   request_bytes;
  logic [bfha_pkg::OFF_W-1:0]   payload_offset;

  modport source(output valid, operation, request_bytes, payload_offset, input ready);
  modport sink(input valid, operation, request_bytes, payload_offset, output ready);
endinterface

interface bfha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [bfha_pkg::OFF_W-1:0]   result_offset;

  modport source(output valid, status, result_offset, input ready);
  modport sink(input valid, status, result_offset, output ready);
endinterface

// ===== hdl/bfha_ram.sv =====
// ----------------------------------------------------------------------------
// bfha_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/best_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator: best-fit allocator over an implicit block list
// Walks block headers in a word RAM to allocate (exact or best fit with
// split) and to free (with coalescing of both neighbors).
// ----------------------------------------------------------------------------
// Allocate walks the block headers, then splits or marks the chosen block,
// then posts the response. Free walks the headers up to the target, then
// frees it and merges it with its free neighbors before the response.
// One request is in work at a time; the single RAM port pair sets the pace.
// After reset a clearing pass over all HEAP_BYTES/4 words builds the initial heap
// while the request channel is held not ready.
module best_fit_heap_allocator #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  bfha_req_if.sink  in_chan,
  bfha_rsp_if.source out_chan
);

  // Heap geometry. Byte positions use XW bits so that sums never wrap.
  localparam int NW     = HEAP_BYTES / 4;
  localparam int WA     = $clog2(NW);
  localparam int HB_LOG = $clog2(HEAP_BYTES);
  localparam int XW     = (HB_LOG + 2 > 17) ? HB_LOG + 2 : 17;
  localparam int WW     = bfha_pkg::WORD_W;
  localparam int OW     = bfha_pkg::OFF_W;

  localparam logic [XW-1:0] END_POS  = XW'(HEAP_BYTES - 4);
  localparam logic [XW-1:0] FIRST    = XW'(4);
  localparam logic [XW-1:0] FOUR     = XW'(4);
  localparam logic [XW-1:0] TWELVE   = XW'(12);
  localparam logic [XW-1:0] NW_X     = XW'(NW);
  localparam logic [XW-1:0] MASK3    = ~XW'(3);
  localparam logic [WW-1:0] INIT_HDR = WW'(HEAP_BYTES - 8) | WW'(2);
  localparam logic [WW-1:0] INIT_FTR = WW'(HEAP_BYTES - 8);
  localparam logic [WA-1:0] FTR_WORD = WA'((HEAP_BYTES - 8) / 4);
  localparam logic [WA-1:0] LAST_W   = WA'(NW - 1);

  // One-hot sequencer states.
  typedef enum logic [20:0] {
    S_CLR   = 21'h000001,
    S_IDLE  = 21'h000002,
    S_ARD   = 21'h000004,
    S_ACHK  = 21'h000008,
    S_XRD   = 21'h000010,
    S_XCHK  = 21'h000020,
    S_SPL1  = 21'h000040,
    S_SPL2  = 21'h000080,
    S_SPL3  = 21'h000100,
    S_FRD   = 21'h000200,
    S_FCHK  = 21'h000400,
    S_FGO   = 21'h000800,
    S_FW2   = 21'h001000,
    S_FNRD  = 21'h002000,
    S_FNCHK = 21'h004000,
    S_FNW2  = 21'h008000,
    S_FNW3  = 21'h010000,
    S_FPV   = 21'h020000,
    S_FPCHK = 21'h040000,
    S_FPW2  = 21'h080000,
    S_DONE  = 21'h100000
  } state_t;

  state_t        state_r;
  logic [WA-1:0] clr_r;
  logic [XW-1:0] pos_r;     // walk position, later the next header
  logic [XW-1:0] need_r;    // rounded block size of an allocate
  logic          have_r;    // a best-fit candidate exists
  logic [XW-1:0] best_r;    // candidate header position
  logic [XW-1:0] bsz_r;     // candidate size
  logic          bprev_r;   // candidate's previous-allocated bit
  logic [XW-1:0] tgt_r;     // header position of the block to free
  logic [XW-1:0] h_r;       // working header of the freed block
  logic [XW-1:0] sz_r;      // size of the freed block
  logic [XW-1:0] nsz_r;     // size of a merged neighbor
  logic          res_fail_r;
  logic [XW-1:0] res_off_r;
  logic          out_valid_r;
  logic          out_status_r;
  logic [OW-1:0] out_off_r;

  // RAM ports.
  logic          ram_we;
  logic [WA-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [WA-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic          wr_en;
  logic [XW-1:0] wr_pos;
  logic [XW-1:0] wr_val;
  logic [XW-1:0] rd_pos;

  logic [XW-1:0] rdx;       // read word, widened
  logic [XW-1:0] rsz;       // read word with flag bits cleared
  logic [XW-1:0] nx_walk;   // next header after pos_r for the read block
  logic [XW-1:0] need_in;
  logic [XW-1:0] off_in;
  logic [WW-1:0] clr_val;

  bfha_ram #(
    .WIDTH(WW),
    .DEPTH(NW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rdx = XW'(ram_rdata);
  assign rsz = rdx & MASK3;

  // Next header position; a zero size or an overrun ends the list.
  assign nx_walk = (rsz == '0 || pos_r + rsz > END_POS) ? END_POS : pos_r + rsz;

  assign need_in = (XW'(in_chan.request_bytes) + XW'(11)) & ~XW'(7);
  assign off_in  = XW'(in_chan.payload_offset);

  always_comb begin
    if (clr_r == WA'(1)) begin
      clr_val = INIT_HDR;
    end else if (clr_r == FTR_WORD) begin
      clr_val = INIT_FTR;
    end else if (clr_r == LAST_W) begin
      clr_val = WW'(1);
    end else begin
      clr_val = '0;
    end
  end

  // Write and read address selection for each sequencer step.
  always_comb begin
    wr_en  = 1'b0;
    wr_pos = '0;
    wr_val = '0;
    rd_pos = pos_r;
    case (state_r)
      S_ACHK: begin
        if (rdx != XW'(1) && rsz != '0 && !rdx[0] && rsz == need_r) begin
          wr_en  = 1'b1;
          wr_pos = pos_r;
          wr_val = rdx | XW'(1);
        end
      end
      S_XCHK: begin
        if (rdx != XW'(1)) begin
          wr_en  = 1'b1;
          wr_pos = pos_r;
          wr_val = rdx | XW'(2);
        end
      end
      S_SPL1: begin
        wr_en  = 1'b1;
        wr_pos = best_r + bsz_r - FOUR;
        wr_val = bsz_r - need_r;
      end
      S_SPL2: begin
        wr_en  = 1'b1;
        wr_pos = best_r;
        wr_val = need_r | XW'({bprev_r, 1'b1});
      end
      S_SPL3: begin
        wr_en  = 1'b1;
        wr_pos = best_r + need_r;
        wr_val = (bsz_r - need_r) | XW'(2);
      end
      S_FGO: begin
        if (h_r[0]) begin
          wr_en  = 1'b1;
          wr_pos = tgt_r;
          wr_val = h_r & ~XW'(1);
        end
      end
      S_FW2: begin
        wr_en  = 1'b1;
        wr_pos = tgt_r + sz_r - FOUR;
        wr_val = sz_r;
      end
      S_FNRD: begin
        rd_pos = tgt_r + sz_r;
      end
      S_FNCHK: begin
        wr_en  = 1'b1;
        wr_pos = tgt_r + sz_r;
        wr_val = rdx & ~XW'(2);
      end
      S_FNW2: begin
        wr_en  = 1'b1;
        wr_pos = tgt_r;
        wr_val = h_r;
      end
      S_FNW3: begin
        wr_en  = 1'b1;
        wr_pos = tgt_r + sz_r + nsz_r - FOUR;
        wr_val = sz_r + nsz_r;
      end
      S_FPV: begin
        rd_pos = tgt_r - FOUR;
      end
      S_FPCHK: begin
        if (rsz != '0 && rsz <= tgt_r - FOUR) begin
          wr_en  = 1'b1;
          wr_pos = tgt_r - rsz;
          wr_val = (h_r & MASK3) + rsz + XW'(2);
        end
      end
      S_FPW2: begin
        wr_en  = 1'b1;
        wr_pos = tgt_r + (h_r & MASK3) - FOUR;
        wr_val = (h_r & MASK3) + nsz_r;
      end
      default: begin
      end
    endcase
  end

  // Writes outside the heap are dropped; the clearing pass owns the port.
  always_comb begin
    if (state_r == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = clr_val;
    end else begin
      ram_we    = wr_en && ((wr_pos >> 2) < NW_X);
      ram_waddr = wr_pos[WA+1:2];
      ram_wdata = wr_val[WW-1:0];
    end
    ram_raddr = rd_pos[WA+1:2];
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.result_offset = out_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The done step reloads the output register itself.
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + WA'(1);
          if (clr_r == LAST_W) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            res_fail_r <= 1'b1;
            res_off_r  <= '0;
            pos_r      <= FIRST;
            have_r     <= 1'b0;
            need_r     <= need_in;
            tgt_r      <= off_in - FOUR;
            if (in_chan.operation == bfha_pkg::OP_ALLOC) begin
              state_r <= (in_chan.request_bytes == '0) ? S_DONE : S_ARD;
            end else if (off_in == '0 || off_in[2:0] != 3'd0 || off_in >= END_POS) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_FRD;
            end
          end
        end
        // Allocate: walk the list, reading one header at a time.
        S_ARD: begin
          if (pos_r >= END_POS) begin
            state_r <= have_r ? S_SPL1 : S_DONE;
          end else begin
            state_r <= S_ACHK;
          end
        end
        S_ACHK: begin
          if (rdx == XW'(1) || rsz == '0) begin
            state_r <= have_r ? S_SPL1 : S_DONE;
          end else if (!rdx[0] && rsz == need_r) begin
            // Exact fit: the header is marked now, then the next header.
            best_r     <= pos_r;
            res_fail_r <= 1'b0;
            res_off_r  <= pos_r + FOUR;
            pos_r      <= nx_walk;
            state_r    <= (nx_walk < END_POS) ? S_XRD : S_DONE;
          end else begin
            if (!rdx[0] && rsz > need_r && (!have_r || rsz < bsz_r)) begin
              have_r  <= 1'b1;
              best_r  <= pos_r;
              bsz_r   <= rsz;
              bprev_r <= rdx[1];
            end
            pos_r   <= nx_walk;
            state_r <= S_ARD;
          end
        end
        S_XRD: begin
          state_r <= S_XCHK;
        end
        S_XCHK: begin
          state_r <= S_DONE;
        end
        S_SPL1: begin
          state_r <= S_SPL2;
        end
        S_SPL2: begin
          state_r <= S_SPL3;
        end
        S_SPL3: begin
          res_fail_r <= 1'b0;
          res_off_r  <= best_r + FOUR;
          state_r    <= S_DONE;
        end
        // Free: find the target header on the list first.
        S_FRD: begin
          state_r <= (pos_r >= END_POS) ? S_DONE : S_FCHK;
        end
        S_FCHK: begin
          if (rdx == XW'(1) || rsz == '0) begin
            state_r <= S_DONE;
          end else if (pos_r == tgt_r) begin
            h_r     <= rdx;
            state_r <= S_FGO;
          end else begin
            pos_r   <= nx_walk;
            state_r <= S_FRD;
          end
        end
        S_FGO: begin
          if (!h_r[0]) begin
            state_r <= S_DONE;
          end else begin
            h_r     <= h_r & ~XW'(1);
            sz_r    <= h_r & MASK3;
            state_r <= S_FW2;
          end
        end
        S_FW2: begin
          res_fail_r <= 1'b0;
          state_r    <= (tgt_r + sz_r < END_POS) ? S_FNRD : S_FPV;
        end
        S_FNRD: begin
          state_r <= S_FNCHK;
        end
        S_FNCHK: begin
          if (!rdx[0]) begin
            nsz_r   <= rsz;
            h_r     <= h_r + rsz;
            state_r <= S_FNW2;
          end else begin
            state_r <= S_FPV;
          end
        end
        S_FNW2: begin
          state_r <= S_FNW3;
        end
        S_FNW3: begin
          state_r <= S_FPV;
        end
        S_FPV: begin
          state_r <= (!h_r[1] && tgt_r >= TWELVE) ? S_FPCHK : S_DONE;
        end
        S_FPCHK: begin
          if (rsz != '0 && rsz <= tgt_r - FOUR) begin
            nsz_r   <= rsz;
            state_r <= S_FPW2;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_FPW2: begin
          state_r <= S_DONE;
        end
        // Post the response once the output register is free.
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_fail_r ? bfha_pkg::ST_FAIL : bfha_pkg::ST_OK;
            out_off_r    <= res_off_r[OW-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> state_r != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !out_valid_r |=> out_valid_r && state_r == S_IDLE)
    else $error("finished request did not reach the output register");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_chan.ready && ram_we)
    else $error("request channel open during the clearing pass");
`endif

endmodule
